// ===== hdl/civil_date_day_count_converter_top_defines.svh =====
// Assertion macros shared by the calendar converter RTL.
`ifndef CIVIL_DATE_DAY_COUNT_CONVERTER_TOP_DEFINES_SVH
`define CIVIL_DATE_DAY_COUNT_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CDCC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CDCC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/cdcc_pkg.sv =====
// Package for the calendar converter: widths, calendar constants, tables and helpers.
package cdcc_pkg;

   // Field widths
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 22;
   localparam int WDAY_W  = 3;
   localparam int DOY_W   = 9;
   localparam int QUO_W   = 14;
   localparam int STEP_W  = 4;

   // Commands
   localparam logic CMD_DATE_TO_COUNT = 1'b0;
   localparam logic CMD_COUNT_TO_DATE = 1'b1;

   // Range limits
   localparam logic [COUNT_W-1:0] MAX_COUNT  = 22'd2932896;
   localparam logic [YEAR_W-1:0]  FIRST_YEAR = 14'd1970;
   localparam logic [YEAR_W-1:0]  LAST_YEAR  = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTHS     = 4'd12;
   localparam logic [MONTH_W-1:0] LAST_MONTH_IDX = 4'd11;

   // Internal day numbering starts on 1601-01-01, the first day of a 400-year cycle
   localparam logic [YEAR_W-1:0]  BASE_YEAR  = 14'd1601;
   localparam logic [COUNT_W-1:0] EPOCH_DAYS = 22'd134774;

   // Days and years in one cycle, century, leap quad and plain year
   localparam logic [COUNT_W-1:0] DAYS_400  = 22'd146097;
   localparam logic [COUNT_W-1:0] DAYS_100  = 22'd36524;
   localparam logic [COUNT_W-1:0] DAYS_4    = 22'd1461;
   localparam logic [COUNT_W-1:0] DAYS_1    = 22'd365;
   localparam logic [COUNT_W-1:0] YEARS_400 = 22'd400;
   localparam logic [COUNT_W-1:0] YEARS_100 = 22'd100;
   localparam logic [COUNT_W-1:0] YEARS_4   = 22'd4;
   localparam logic [COUNT_W-1:0] YEARS_1   = 22'd1;

   // Restoring steps: 5 for cycles, 2 for centuries, 5 for quads, 2 for years
   localparam logic [STEP_W-1:0] DIV_LAST   = 4'd13;
   localparam logic [STEP_W-1:0] MONTH_LAST = 4'd3;

   localparam logic [3:0] DAYS_PER_WEEK = 4'd7;

   // Control from the sequencer to the shared step unit
   typedef struct packed {
      logic               load;
      logic               step;
      logic [COUNT_W-1:0] rem_init;
      logic [COUNT_W-1:0] sub_val;
      logic [COUNT_W-1:0] add_val;
   } cdcc_ctl_type;

   // Shift of the step constant for a restoring step
   function automatic logic [2:0] div_shift(input logic [STEP_W-1:0] step);
      logic [2:0] sh;
      case (step) inside
         [4'd0:4'd4]:  sh = 3'(4'd4 - step);
         [4'd5:4'd6]:  sh = 3'(4'd6 - step);
         [4'd7:4'd11]: sh = 3'(4'd11 - step);
         default:      sh = 3'(4'd13 - step);
      endcase
      return sh;
   endfunction

   // Day weight of a restoring step
   function automatic logic [COUNT_W-1:0] div_days(input logic [STEP_W-1:0] step);
      logic [COUNT_W-1:0] base;
      case (step) inside
         [4'd0:4'd4]:  base = DAYS_400;
         [4'd5:4'd6]:  base = DAYS_100;
         [4'd7:4'd11]: base = DAYS_4;
         default:      base = DAYS_1;
      endcase
      return base << div_shift(step);
   endfunction

   // Year weight of a restoring step
   function automatic logic [COUNT_W-1:0] div_years(input logic [STEP_W-1:0] step);
      logic [COUNT_W-1:0] base;
      case (step) inside
         [4'd0:4'd4]:  base = YEARS_400;
         [4'd5:4'd6]:  base = YEARS_100;
         [4'd7:4'd11]: base = YEARS_4;
         default:      base = YEARS_1;
      endcase
      return base << div_shift(step);
   endfunction

   // Days before month idx+1 (idx is 0 for January)
   function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] idx,
                                                    input logic leap);
      logic [DOY_W-1:0] s;
      case (idx)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd59;
         4'd3:    s = 9'd90;
         4'd4:    s = 9'd120;
         4'd5:    s = 9'd151;
         4'd6:    s = 9'd181;
         4'd7:    s = 9'd212;
         4'd8:    s = 9'd243;
         4'd9:    s = 9'd273;
         4'd10:   s = 9'd304;
         4'd11:   s = 9'd334;
         default: s = 9'd0;
      endcase
      if (leap && (idx >= 4'd2) && (idx <= LAST_MONTH_IDX)) begin
         s = s + 9'd1;
      end
      return s;
   endfunction

   // Length of month m (1 for January)
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m) inside
         4'd2:                     len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
         default:                  len = 5'd31;
      endcase
      return len;
   endfunction

   // Leap flag from the quotient bits {cycles, centuries, quads, years} of year-1601
   function automatic logic is_leap(input logic [QUO_W-1:0] q);
      logic last_of_quad;
      logic last_quad;
      logic last_century;
      last_of_quad = (q[1:0] == 2'd3);
      last_quad    = (q[6:2] == 5'd24);
      last_century = (q[8:7] == 2'd3);
      return last_of_quad && (!last_quad || last_century);
   endfunction

   // Weekday, 1 Monday to 7 Sunday; 1601-01-01 was a Monday and the cycle is whole weeks
   function automatic logic [WDAY_W-1:0] weekday_of(input logic [QUO_W-1:0] q,
                                                    input logic [DOY_W-1:0] doy);
      logic [DOY_W-1:0] sum;
      logic [4:0]       oct;
      logic [3:0]       fold;
      // century and quad lengths are both 5 mod 7, a year is 1 mod 7
      sum  = 9'(q[8:7]) * 9'd5 + 9'(q[6:2]) * 9'd5 + 9'(q[1:0]) + doy;
      // 8 is 1 mod 7: fold octal digits
      oct  = 5'(sum[8:6]) + 5'(sum[5:3]) + 5'(sum[2:0]);
      fold = 4'(oct[4:3]) + 4'(oct[2:0]);
      if (fold >= DAYS_PER_WEEK) begin
         fold = fold - DAYS_PER_WEEK;
      end
      return 3'(fold) + 3'd1;
   endfunction

endpackage

// ===== hdl/cdcc_if.sv =====
// Valid/ready channel interfaces for converter requests and responses.
interface cdcc_req_if import cdcc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               command;
   logic [DAY_W-1:0]   day_in;
   logic [MONTH_W-1:0] month_in;
   logic [YEAR_W-1:0]  year_in;
   logic [COUNT_W-1:0] count_in;

   modport source (output valid, command, day_in, month_in, year_in, count_in,
                   input ready);
   modport sink   (input valid, command, day_in, month_in, year_in, count_in,
                   output ready);
endinterface

interface cdcc_rsp_if import cdcc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] day_count;
   logic [DAY_W-1:0]   day_out;
   logic [MONTH_W-1:0] month_out;
   logic [YEAR_W-1:0]  year_out;
   logic [WDAY_W-1:0]  weekday_out;
   logic               date_valid;

   modport source (output valid, day_count, day_out, month_out, year_out, weekday_out,
                   date_valid, input ready);
   modport sink   (input valid, day_count, day_out, month_out, year_out, weekday_out,
                   date_valid, output ready);
endinterface

// ===== hdl/cdcc_step.sv =====
// Shared conditional subtract / accumulate unit with its remainder and accumulator.
module cdcc_step import cdcc_pkg::*; (
   input  logic               clock,
   input  cdcc_ctl_type       ctl,
   output logic [COUNT_W-1:0] rem,
   output logic [COUNT_W-1:0] acc,
   output logic               take
);

   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] acc_ff, acc_in;

   // Compare decides the step; subtract and accumulate follow it
   assign take = (rem_ff >= ctl.sub_val);

   always_comb begin
      rem_in = rem_ff;
      acc_in = acc_ff;
      if (ctl.load) begin
         rem_in = ctl.rem_init;
         acc_in = '0;
      end else if (ctl.step && take) begin
         rem_in = rem_ff - ctl.sub_val;
         acc_in = acc_ff + ctl.add_val;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   assign rem = rem_ff;
   assign acc = acc_ff;

endmodule

// ===== hdl/civil_date_day_count_converter_top.sv =====
// Calendar converter top: sequencer, operand selection and response register.
//
//   channel   | dir | transaction carries
//   ----------+-----+------------------------------------------------------------
//   req_chan  | in  | command, day_in, month_in, year_in, count_in
//   rsp_chan  | out | day_count, day_out, month_out, year_out, weekday_out, date_valid
//
// Count to date: response after 14 restoring steps, 4 month search steps, finish and
// output load; date to count: 14 steps, finish, epoch, load; day past the month's end:
// 14 steps, finish, load; other out-of-range fields: load only. Then idle for the next accept.
// All steps run through the one subtract/accumulate unit, one step per cycle.
// req_chan.ready is high only while the sequencer is idle; a finished response waits
// in the output register, so a new request is taken while rsp_chan is stalled.
// Synchronous active-high reset clears the sequencer and the response valid.
`include "civil_date_day_count_converter_top_defines.svh"

module civil_date_day_count_converter_top import cdcc_pkg::*; (
   input logic         clock,
   input logic         reset,
   cdcc_req_if.sink    req_chan,
   cdcc_rsp_if.source  rsp_chan
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_MONTH  = 3'd2;
   localparam logic [2:0] ST_FINISH = 3'd3;
   localparam logic [2:0] ST_EPOCH  = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   // Control state
   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic               cmd_ff, cmd_in;
   logic               bad_ff, bad_in;
   logic [DAY_W-1:0]   day_ff, day_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [WDAY_W-1:0]  wday_ff, wday_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;

   // Response payload
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic [DAY_W-1:0]   out_day_ff, out_day_in;
   logic [MONTH_W-1:0] out_month_ff, out_month_in;
   logic [YEAR_W-1:0]  out_year_ff, out_year_in;
   logic [WDAY_W-1:0]  out_wday_ff, out_wday_in;
   logic               out_good_ff, out_good_in;

   // Step unit
   cdcc_ctl_type       ctl;
   logic [COUNT_W-1:0] rem;
   logic [COUNT_W-1:0] acc;
   logic               take;

   logic               leap;
   logic               out_free;
   logic [4:0]         cand;
   logic [DOY_W-1:0]   doy;

   // Check terms
   logic               req_fire;
   logic               fields_ok;
   logic               fields_zero;

   cdcc_step u_step (
      .clock (clock),
      .ctl   (ctl),
      .rem   (rem),
      .acc   (acc),
      .take  (take)
   );

   assign leap     = is_leap(quo_ff);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // Month search candidate: binary steps of 8, 4, 2, 1 months
   assign cand = {1'b0, month_ff} + (5'd8 >> step_ff[1:0]);

   // Day of year for the weekday, from either direction
   always_comb begin
      if (cmd_ff == CMD_COUNT_TO_DATE) begin
         doy = rem[DOY_W-1:0] + month_start(month_ff, leap);
      end else begin
         doy = month_start(4'(month_ff - 4'd1), leap) + 9'(day_ff) - 9'd1;
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      cmd_in       = cmd_ff;
      bad_in       = bad_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      wday_in      = wday_ff;
      count_in     = count_ff;
      quo_in       = quo_ff;
      out_count_in = out_count_ff;
      out_day_in   = out_day_ff;
      out_month_in = out_month_ff;
      out_year_in  = out_year_ff;
      out_wday_in  = out_wday_ff;
      out_good_in  = out_good_ff;

      ctl.load     = 1'b0;
      ctl.step     = 1'b0;
      ctl.sub_val  = '0;
      ctl.add_val  = '0;
      if (req_chan.command == CMD_COUNT_TO_DATE) begin
         ctl.rem_init = req_chan.count_in + EPOCH_DAYS;
      end else begin
         ctl.rem_init = COUNT_W'(req_chan.year_in - BASE_YEAR);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               ctl.load = 1'b1;
               cmd_in   = req_chan.command;
               day_in   = req_chan.day_in;
               year_in  = req_chan.year_in;
               count_in = req_chan.count_in;
               quo_in   = '0;
               step_in  = '0;
               if (req_chan.command == CMD_COUNT_TO_DATE) begin
                  month_in = '0;
                  bad_in   = (req_chan.count_in > MAX_COUNT);
               end else begin
                  month_in = req_chan.month_in;
                  bad_in   = (req_chan.year_in < FIRST_YEAR) ||
                             (req_chan.year_in > LAST_YEAR) ||
                             (req_chan.month_in == '0) ||
                             (req_chan.month_in > MONTHS) ||
                             (req_chan.day_in == '0);
               end
               state_in = bad_in ? ST_EMIT : ST_DIV;
            end
         end

         // Restoring steps over cycles, centuries, quads and years
         ST_DIV: begin
            ctl.step = 1'b1;
            if (cmd_ff == CMD_COUNT_TO_DATE) begin
               ctl.sub_val = div_days(step_ff);
               ctl.add_val = div_years(step_ff);
            end else begin
               ctl.sub_val = div_years(step_ff);
               ctl.add_val = div_days(step_ff);
            end
            quo_in  = {quo_ff[QUO_W-2:0], take};
            step_in = step_ff + 4'd1;
            if (step_ff == DIV_LAST) begin
               step_in  = '0;
               state_in = (cmd_ff == CMD_COUNT_TO_DATE) ? ST_MONTH : ST_FINISH;
            end
         end

         // Binary month search; the remainder tracks days past the chosen month start
         ST_MONTH: begin
            ctl.step = 1'b1;
            if (cand <= 5'(LAST_MONTH_IDX)) begin
               ctl.sub_val = COUNT_W'(month_start(cand[MONTH_W-1:0], leap) -
                                      month_start(month_ff, leap));
            end else begin
               ctl.sub_val = '1;
            end
            if (take) begin
               month_in = cand[MONTH_W-1:0];
            end
            step_in = step_ff + 4'd1;
            if (step_ff == MONTH_LAST) begin
               step_in  = '0;
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            wday_in = weekday_of(quo_ff, doy);
            if (cmd_ff == CMD_COUNT_TO_DATE) begin
               day_in   = rem[DAY_W-1:0] + 5'd1;
               month_in = month_ff + 4'd1;
               year_in  = acc[YEAR_W-1:0] + BASE_YEAR;
               state_in = ST_EMIT;
            end else if (day_ff > month_len(month_ff, leap)) begin
               bad_in   = 1'b1;
               state_in = ST_EMIT;
            end else begin
               // zero subtrahend always takes: plain accumulate
               ctl.step    = 1'b1;
               ctl.add_val = COUNT_W'(doy);
               state_in    = ST_EPOCH;
            end
         end

         // Move from the 1601 numbering to the 1970 epoch
         ST_EPOCH: begin
            ctl.step    = 1'b1;
            ctl.add_val = COUNT_W'(0) - EPOCH_DAYS;
            state_in    = ST_EMIT;
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               out_good_in  = !bad_ff;
               if (bad_ff) begin
                  out_count_in = '0;
                  out_day_in   = '0;
                  out_month_in = '0;
                  out_year_in  = '0;
                  out_wday_in  = '0;
               end else begin
                  out_count_in = (cmd_ff == CMD_COUNT_TO_DATE) ? count_ff : acc;
                  out_day_in   = day_ff;
                  out_month_in = month_ff;
                  out_year_in  = year_ff;
                  out_wday_in  = wday_ff;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      bad_ff       <= bad_in;
      day_ff       <= day_in;
      month_ff     <= month_in;
      year_ff      <= year_in;
      wday_ff      <= wday_in;
      count_ff     <= count_in;
      quo_ff       <= quo_in;
      out_count_ff <= out_count_in;
      out_day_ff   <= out_day_in;
      out_month_ff <= out_month_in;
      out_year_ff  <= out_year_in;
      out_wday_ff  <= out_wday_in;
      out_good_ff  <= out_good_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.day_count   = out_count_ff;
   assign rsp_chan.day_out     = out_day_ff;
   assign rsp_chan.month_out   = out_month_ff;
   assign rsp_chan.year_out    = out_year_ff;
   assign rsp_chan.weekday_out = out_wday_ff;
   assign rsp_chan.date_valid  = out_good_ff;

   // Checks
   assign req_fire    = req_chan.valid && req_chan.ready;
   assign fields_ok   = (out_month_ff >= 4'd1) && (out_month_ff <= MONTHS) &&
                        (out_day_ff != '0) && (out_wday_ff != '0) &&
                        (out_year_ff >= FIRST_YEAR);
   assign fields_zero = (out_count_ff == '0) && (out_day_ff == '0) && (out_month_ff == '0) &&
                        (out_year_ff == '0) && (out_wday_ff == '0);

   `CDCC_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_chan.ready, "accept while busy")
   `CDCC_ASSERT_NOW(a_good_fields, rsp_valid_ff && out_good_ff, fields_ok, "bad date field")
   `CDCC_ASSERT_NOW(a_bad_zero, rsp_valid_ff && !out_good_ff, fields_zero, "nonzero bad response")
   `CDCC_ASSERT_NOW(a_step_bound, state_ff == ST_DIV, step_ff <= DIV_LAST, "step out of range")

endmodule

// ===== sim/civil_date_day_count_converter_top_test.sv =====
// Self-checking testbench for the calendar date / day count converter.
module civil_date_day_count_converter_top_test import cdcc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT     = 4000;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_CYCLES    = 40;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      logic               command;
      logic [DAY_W-1:0]   day_in;
      logic [MONTH_W-1:0] month_in;
      logic [YEAR_W-1:0]  year_in;
      logic [COUNT_W-1:0] count_in;
   } date_request_type;

   typedef struct packed {
      logic [COUNT_W-1:0] day_count;
      logic [DAY_W-1:0]   day_out;
      logic [MONTH_W-1:0] month_out;
      logic [YEAR_W-1:0]  year_out;
      logic [WDAY_W-1:0]  weekday_out;
      logic               date_valid;
   } conversion_type;

   // Predicts each conversion and checks responses in order
   class conversion_scoreboard_type;
      conversion_type expected_q[$];
      int unsigned mismatches;

      static function bit is_leap_year(int unsigned y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      static function int unsigned days_in_month(int unsigned m, int unsigned y);
         case (m)
            2:           return is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
         endcase
      endfunction

      // Days from 1970-01-01 to January 1 of year y; leap years 1970..y-1 add one each
      static function int unsigned days_before_year(int unsigned y);
         int unsigned p;
         p = y - 1;
         return (y - 1970) * 365 + (p / 4 - 1969 / 4) - (p / 100 - 1969 / 100)
                + (p / 400 - 1969 / 400);
      endfunction

      static function conversion_type predict(date_request_type r);
         conversion_type c;
         int unsigned cnt, y, m, rem;
         int unsigned in_day, in_month, in_year;
         c = '0;
         in_day   = 32'(r.day_in);
         in_month = 32'(r.month_in);
         in_year  = 32'(r.year_in);
         if (r.command == CMD_DATE_TO_COUNT) begin
            if (r.year_in < FIRST_YEAR || r.year_in > LAST_YEAR) return c;
            if (r.month_in < 1 || r.month_in > MONTHS) return c;
            if (in_day == 0 || in_day > days_in_month(in_month, in_year)) return c;
            cnt = days_before_year(in_year);
            for (int unsigned i = 1; i < in_month; i++) cnt += days_in_month(i, in_year);
            cnt += in_day - 1;
         end else begin
            if (r.count_in > MAX_COUNT) return c;
            cnt = 32'(r.count_in);
         end
         // walk back from an estimate of the year, then through the months
         y = 1970 + cnt / 365;
         while (y > 1970 && days_before_year(y) > cnt) y--;
         rem = cnt - days_before_year(y);
         m = 1;
         while (m < 12 && rem >= days_in_month(m, y)) begin
            rem -= days_in_month(m, y);
            m++;
         end
         c.day_count   = COUNT_W'(cnt);
         c.day_out     = DAY_W'(rem + 1);
         c.month_out   = MONTH_W'(m);
         c.year_out    = YEAR_W'(y);
         // 1970-01-01 was a Thursday
         c.weekday_out = WDAY_W'((cnt + 3) % 7 + 1);
         c.date_valid  = 1'b1;
         return c;
      endfunction

      static function string describe(conversion_type c);
         return $sformatf("count=%0d date=%0d-%0d-%0d wd=%0d valid=%0b", c.day_count,
                          c.year_out, c.month_out, c.day_out, c.weekday_out, c.date_valid);
      endfunction

      function void note_request(date_request_type r);
         expected_q.push_back(predict(r));
      endfunction

      function void check_response(conversion_type got);
         conversion_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: response with none expected: %s", $realtime, describe(got));
            return;
         end
         want = expected_q.pop_front();
         if (got.day_count !== want.day_count || got.day_out !== want.day_out ||
             got.month_out !== want.month_out || got.year_out !== want.year_out ||
             got.weekday_out !== want.weekday_out || got.date_valid !== want.date_valid) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: mismatch expected %s", $realtime, describe(want));
               $display("%0t:          actual   %s", $realtime, describe(got));
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int unsigned req_idle_pct;
   int unsigned rsp_stall_pct;
   bit          hold_request;
   int unsigned hold_left;
   int unsigned quiet_cycles;
   conversion_scoreboard_type sb;

   cdcc_req_if req_chan ();
   cdcc_rsp_if rsp_chan ();

   civil_date_day_count_converter_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result side: random stalls plus an optional long hold-off
   initial begin
      rsp_chan.ready <= 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_left != 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Transaction monitor feeding the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_request({req_chan.command, req_chan.day_in, req_chan.month_in,
                             req_chan.year_in, req_chan.count_in});
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_response({rsp_chan.day_count, rsp_chan.day_out, rsp_chan.month_out,
                               rsp_chan.year_out, rsp_chan.weekday_out,
                               rsp_chan.date_valid});
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("civil_date_day_count_converter_top_test: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic date_request_type date_item(int unsigned d, int unsigned m,
                                                  int unsigned y);
      return {CMD_DATE_TO_COUNT, DAY_W'(d), MONTH_W'(m), YEAR_W'(y), {COUNT_W{1'b1}}};
   endfunction

   function automatic date_request_type count_item(int unsigned cnt);
      return {CMD_COUNT_TO_DATE, {DAY_W{1'b1}}, {MONTH_W{1'b1}}, {YEAR_W{1'b1}},
              COUNT_W'(cnt)};
   endfunction

   // Mostly well-formed dates and counts, some near the edges, some fully random
   function automatic date_request_type random_request();
      date_request_type r;
      int unsigned mode, y, m, len;
      r.command  = $urandom_range(1) ? CMD_COUNT_TO_DATE : CMD_DATE_TO_COUNT;
      r.day_in   = DAY_W'($urandom_range(31));
      r.month_in = MONTH_W'($urandom_range(15));
      r.year_in  = YEAR_W'($urandom_range(16383));
      r.count_in = COUNT_W'($urandom_range(4194303));
      mode = $urandom_range(99);
      if (r.command == CMD_DATE_TO_COUNT) begin
         if (mode < 80) begin
            if (mode < 15) begin
               case ($urandom_range(3))
                  0:       y = 32'(FIRST_YEAR);
                  1:       y = 32'(LAST_YEAR);
                  2:       y = 2000;
                  default: y = 2100;
               endcase
            end else begin
               y = $urandom_range(LAST_YEAR, FIRST_YEAR);
            end
            m = $urandom_range(12, 1);
            len = conversion_scoreboard_type::days_in_month(m, y);
            r.year_in  = YEAR_W'(y);
            r.month_in = MONTH_W'(m);
            if (mode % 4 == 0) r.day_in = DAY_W'(len + $urandom_range(1));
            else               r.day_in = DAY_W'($urandom_range(len, 1));
         end
      end else begin
         if (mode < 70)      r.count_in = COUNT_W'($urandom_range(MAX_COUNT));
         else if (mode < 85) r.count_in = COUNT_W'(MAX_COUNT - 3 + $urandom_range(6));
      end
      return r;
   endfunction

   task automatic send_request(input date_request_type r);
      // sender idle cycles, one draw per cycle
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.command  <= r.command;
      req_chan.day_in   <= r.day_in;
      req_chan.month_in <= r.month_in;
      req_chan.year_in  <= r.year_in;
      req_chan.count_in <= r.count_in;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Main sequence
   initial begin
      sb = new();
      quiet_cycles  = 0;
      hold_request  = 1'b0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      reset <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.command  <= CMD_DATE_TO_COUNT;
      req_chan.day_in   <= '0;
      req_chan.month_in <= '0;
      req_chan.year_in  <= '0;
      req_chan.count_in <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: range edges, leap rules, bad fields, count limits
      send_request(date_item(1, 1, 1970));
      send_request(date_item(31, 12, 9999));
      send_request(date_item(29, 2, 2000));
      send_request(date_item(29, 2, 2100));
      send_request(date_item(29, 2, 2024));
      send_request(date_item(29, 2, 2023));
      send_request(date_item(31, 12, 1969));
      send_request(date_item(1, 1, 10000));
      send_request(date_item(31, 15, 16383));
      send_request(date_item(0, 0, 0));
      send_request(date_item(0, 6, 2020));
      send_request(date_item(31, 4, 2021));
      send_request(date_item(15, 13, 2020));
      send_request(date_item(30, 4, 2021));
      send_request(date_item(31, 12, 2024));
      send_request(count_item(0));
      send_request(count_item(32'(MAX_COUNT)));
      send_request(count_item(32'(MAX_COUNT) + 1));
      send_request(count_item(4194303));
      send_request(count_item(11016));
      send_request(count_item(11321));
      send_request(count_item(3));

      // random phases with different idle and stall mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin req_idle_pct = 54; rsp_stall_pct = 0;  end
            2:       begin req_idle_pct = 0;  rsp_stall_pct = 54; end
            default: begin req_idle_pct = 15; rsp_stall_pct = 15; end
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // long receiver hold-off while requests keep coming
            if (phase == 0 && i == 60) hold_request = 1'b1;
            send_request(random_request());
         end
      end
      req_chan.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("civil_date_day_count_converter_top_test: PASS");
      end else begin
         $display("civil_date_day_count_converter_top_test: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/cdcc_pkg.sv
hdl/cdcc_if.sv
hdl/cdcc_step.sv
hdl/civil_date_day_count_converter_top.sv
sim/civil_date_day_count_converter_top_test.sv
